// ===== src/cdte_pkg.sv =====
// ============================================================================
// cdte_pkg - character display text engine shared definitions
// Item kinds, action codes, character constants and the store control group.
// ============================================================================
package cdte_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_ACTION = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Decoded actions; codes above ACT_DOWN do nothing
    typedef enum logic [3:0] {
        ACT_BACKDEL = 4'd0,
        ACT_FWDDEL  = 4'd1,
        ACT_ERASE   = 4'd2,
        ACT_CLEAR   = 4'd3,
        ACT_ERASEOL = 4'd4,
        ACT_HOME    = 4'd5,
        ACT_END     = 4'd6,
        ACT_LEFT    = 4'd7,
        ACT_RIGHT   = 4'd8,
        ACT_UP      = 4'd9,
        ACT_DOWN    = 4'd10
    } action_t;

    // Characters
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [6:0] MAX_BRIGHT = 7'd100;

    // Store port control
    typedef struct packed {
        logic wen;  // write one cell
        logic ren;  // read one cell
        logic clr;  // every cell back to blank
    } store_ctl_t;

endpackage

// ===== src/cdte_screen_ram.sv =====
// ============================================================================
// cdte_screen_ram - screen character store
// One write and one registered read port; per-cell valid flags make unwritten
// or cleared cells read as blank.
// ============================================================================
module cdte_screen_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cdte_pkg::store_ctl_t   ctl,
    input  logic [AW-1:0]          waddr,
    input  logic [7:0]             wdata,
    input  logic [AW-1:0]          raddr,
    output logic [7:0]             rdata
);

    logic [7:0]       screen_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wen) begin
            screen_reg[waddr] <= wdata;
        end
        if (ctl.ren) begin
            rdata_reg <= screen_reg[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (ctl.clr) begin
                valid_reg <= '0;
            end else if (ctl.wen) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (ctl.ren) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : cdte_pkg::CH_BLANK;

endmodule

// ===== src/char_display_text_engine_top.sv =====
// Flow: an accepted word goes from idle straight to the result state for text,
// cursor moves, clear and cell reads; delete and erase first walk the store, up
// to COLUMNS cells. A new word is taken only once the last result is loaded;
// the walk through the store, one cell per cycle on its single read and write
// port, sets the pace, and a stalled receiver holds the result state.
// Reset: synchronous on aresetn low; the store reads as blank at once, no sweep.
// ============================================================================
// char_display_text_engine_top - character screen text engine
// Keeps a ROWS x COLUMNS character store and a cursor; takes text bytes,
// decoded actions and cell reads, and returns one result word per input word.
// ============================================================================
module char_display_text_engine_top #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wen,
    input  logic [6:0] cfg_wdata,
    // input words
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_char_code,
    input  logic [3:0] s_action_code,
    input  logic [7:0] s_repeat_count,
    input  logic       s_read_row,
    input  logic [3:0] s_read_col,
    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_data,
    output logic       m_cursor_row,
    output logic [4:0] m_cursor_col,
    output logic       m_backlight_on
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS + 1);   // column incl. past-end value
    localparam int SW    = ((CW > 8) ? CW : 8) + 1; // room for col + count

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] COL_PAST = CW'(COLUMNS);
    localparam logic [SW-1:0] COLS_W   = SW'(COLUMNS);
    localparam logic [SW-1:0] ROWS_W   = SW'(ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic r, input logic [CW-1:0] c);
        cell_addr = r ? (AW'(COLUMNS) + AW'(c)) : AW'(c);
    endfunction

    state_t        state_reg;
    logic          row_reg;
    logic [CW-1:0] col_reg;
    logic [6:0]    bright_reg;

    // walk: destination j from j_reg to end_reg takes cell j + shift_reg,
    // or a blank where that lies past the row end
    logic [CW-1:0] j_reg;
    logic [CW-1:0] end_reg;
    logic [CW-1:0] shift_reg;
    logic          pend_valid_reg;
    logic [CW-1:0] pend_dst_reg;
    logic          pend_mem_reg;
    logic          hit_reg;

    logic          m_valid_reg;
    logic [7:0]    m_cell_reg;
    logic          m_row_reg;
    logic [4:0]    m_col_reg;
    logic          m_bl_reg;

    // decode of the word on the input, used at acceptance
    logic          dec_row;
    logic [CW-1:0] dec_col;
    logic          dec_walk;
    logic [CW-1:0] dec_j;
    logic [CW-1:0] dec_end;
    logic [CW-1:0] dec_shift;
    logic          dec_we;
    logic          dec_clr;
    logic          dec_rd;
    logic          dec_hit;

    logic          accept;
    logic          resp_load;
    logic [CW:0]   src;
    logic          from_mem;

    cdte_pkg::store_ctl_t ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // result register free or emptying this cycle
    assign resp_load = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        cdte_pkg::action_t act;
        logic              do_act;
        logic [SW-1:0]     cnt;
        logic [SW-1:0]     col_w;
        logic [SW-1:0]     row_w;
        logic [SW-1:0]     k;
        logic [SW-1:0]     t;

        act       = cdte_pkg::ACT_HOME;
        do_act    = 1'b0;
        cnt       = SW'(s_repeat_count);
        col_w     = SW'(col_reg);
        row_w     = SW'(row_reg);
        k         = '0;
        t         = '0;
        dec_row   = row_reg;
        dec_col   = col_reg;
        dec_walk  = 1'b0;
        dec_j     = col_reg;
        dec_end   = COL_LAST;
        dec_shift = COL_PAST;
        dec_we    = 1'b0;
        dec_clr   = 1'b0;
        dec_rd    = 1'b0;
        dec_hit   = (int'(s_read_row) < ROWS) && (SW'(s_read_col) < COLS_W);

        case (s_kind)
            cdte_pkg::KIND_TEXT: begin
                if (s_char_code < cdte_pkg::CH_BLANK) begin
                    if (s_char_code == cdte_pkg::CH_BS) begin
                        act    = cdte_pkg::ACT_BACKDEL;
                        cnt    = SW'(1);
                        do_act = 1'b1;
                    end else if (s_char_code == cdte_pkg::CH_CR) begin
                        // column home, then one row down
                        dec_col = '0;
                        act     = cdte_pkg::ACT_DOWN;
                        cnt     = SW'(1);
                        do_act  = 1'b1;
                    end
                end else if (s_char_code == cdte_pkg::CH_DEL) begin
                    act    = cdte_pkg::ACT_FWDDEL;
                    cnt    = SW'(1);
                    do_act = 1'b1;
                end else if (!s_char_code[7] && (col_reg < COL_PAST)) begin
                    dec_we  = 1'b1;
                    dec_col = col_reg + CW'(1);
                end
            end
            cdte_pkg::KIND_ACTION: begin
                act    = cdte_pkg::action_t'(s_action_code);
                do_act = 1'b1;
            end
            cdte_pkg::KIND_READ: begin
                dec_rd = 1'b1;
            end
            default: ;
        endcase

        if (do_act) begin
            case (act)
                cdte_pkg::ACT_BACKDEL: begin
                    if ((col_w != '0) && (cnt != '0)) begin
                        k         = (cnt > col_w) ? col_w : cnt;
                        dec_col   = CW'(col_w - k);
                        dec_j     = CW'(col_w - k);
                        dec_shift = CW'(k);
                        dec_walk  = 1'b1;
                    end
                end
                cdte_pkg::ACT_FWDDEL: begin
                    if ((cnt != '0) && (col_w < COLS_W)) begin
                        t         = COLS_W - col_w;
                        dec_shift = CW'((cnt < t) ? cnt : t);
                        dec_walk  = 1'b1;
                    end
                end
                cdte_pkg::ACT_ERASE: begin
                    if ((cnt != '0) && (col_w < COLS_W)) begin
                        t        = col_w + cnt - SW'(1);
                        dec_end  = (t >= COLS_W) ? COL_LAST : CW'(t);
                        dec_walk = 1'b1;
                    end
                end
                cdte_pkg::ACT_CLEAR: begin
                    dec_clr = 1'b1;
                    dec_row = 1'b0;
                    dec_col = '0;
                end
                cdte_pkg::ACT_ERASEOL: begin
                    dec_walk = (col_w < COLS_W);
                end
                cdte_pkg::ACT_HOME: begin
                    dec_row = 1'b0;
                    dec_col = '0;
                end
                cdte_pkg::ACT_END: begin
                    dec_col = COL_LAST;
                end
                cdte_pkg::ACT_LEFT: begin
                    dec_col = (cnt >= col_w) ? '0 : CW'(col_w - cnt);
                end
                cdte_pkg::ACT_RIGHT: begin
                    t       = col_w + cnt;
                    dec_col = (t >= COLS_W) ? COL_LAST : CW'(t);
                end
                cdte_pkg::ACT_UP: begin
                    dec_row = (cnt >= row_w) ? 1'b0 : 1'(row_w - cnt);
                end
                cdte_pkg::ACT_DOWN: begin
                    t       = row_w + cnt;
                    dec_row = (t >= ROWS_W) ? 1'(ROWS - 1) : 1'(t);
                end
                default: ;
            endcase
        end
    end

    // source cell of the current walk step
    assign src      = (CW + 1)'(j_reg) + (CW + 1)'(shift_reg);
    assign from_mem = (src < (CW + 1)'(COLUMNS));

    // store port: a pending walk write never meets a text write (walk only)
    always_comb begin
        ctl.wen = pend_valid_reg || (accept && dec_we);
        ctl.ren = (accept && dec_rd && dec_hit) || ((state_reg == ST_WALK) && from_mem);
        ctl.clr = accept && dec_clr;
        waddr   = pend_valid_reg ? cell_addr(row_reg, pend_dst_reg)
                                 : cell_addr(row_reg, col_reg);
        wdata   = pend_valid_reg ? (pend_mem_reg ? rdata : cdte_pkg::CH_BLANK)
                                 : s_char_code;
        raddr   = (state_reg == ST_WALK) ? cell_addr(row_reg, src[CW-1:0])
                                         : cell_addr(s_read_row, CW'(s_read_col));
    end

    cdte_screen_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    // brightness: out-of-range writes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= '0;
        end else if (cfg_wen && (cfg_wdata <= cdte_pkg::MAX_BRIGHT)) begin
            bright_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_reg        <= 1'b0;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
        end else begin
            // each walk step leaves one write for the following cycle
            pend_valid_reg <= (state_reg == ST_WALK);
            if (resp_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        row_reg   <= dec_row;
                        col_reg   <= dec_col;
                        hit_reg   <= dec_rd && dec_hit;
                        j_reg     <= dec_j;
                        end_reg   <= dec_end;
                        shift_reg <= dec_shift;
                        state_reg <= dec_walk ? ST_WALK : ST_RESP;
                    end
                end
                ST_WALK: begin
                    // read source now, write destination next cycle
                    pend_dst_reg   <= j_reg;
                    pend_mem_reg   <= from_mem;
                    if (j_reg == end_reg) begin
                        state_reg <= ST_RESP;
                    end else begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                ST_RESP: begin
                    if (resp_load) begin
                        m_cell_reg  <= hit_reg ? rdata : 8'h00;
                        m_row_reg   <= row_reg;
                        m_col_reg   <= 5'(col_reg);
                        m_bl_reg    <= (bright_reg != '0);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_data    = m_cell_reg;
    assign m_cursor_row   = m_row_reg;
    assign m_cursor_col   = m_col_reg;
    assign m_backlight_on = m_bl_reg;

    // no walk write may be left over once a new word can come in
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("walk write pending in idle");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= COL_PAST))
        else $error("cursor column beyond row end");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(row_reg) < ROWS))
        else $error("cursor row beyond screen");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (j_reg <= end_reg))
        else $error("walk index passed its end");

    a_read_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == cdte_pkg::KIND_READ)) |=> (state_reg == ST_RESP))
        else $error("cell read did not go straight to result");

endmodule

// ===== sim/char_display_text_engine_top_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// char_display_text_engine_top_test - self-checking bench for the text engine
// Drives text bytes, decoded actions and cell reads through the input channel.
// A behavioural shadow of the 2x16 screen, the cursor and the brightness
// register predicts every result word, and a monitor compares them in order.
// Random idling on both sides, a long receiver hold-off and several
// brightness settings are covered.
// ============================================================================
module char_display_text_engine_top_test;

    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;
    // kind 3 is not decoded by the block
    localparam logic [1:0] KIND_NONE = 2'd3;
    // text bytes from here up are dropped
    localparam int CH_TOP = 128;

    // one expected result word
    typedef struct {
        logic [7:0] char_out;
        logic       row_out;
        logic [4:0] col_out;
        logic       light_out;
    } screen_result_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wen;
    logic [6:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_kind;
    logic [7:0] s_char_code;
    logic [3:0] s_action_code;
    logic [7:0] s_repeat_count;
    logic       s_read_row;
    logic [3:0] s_read_col;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_cell_data;
    logic       m_cursor_row;
    logic [4:0] m_cursor_col;
    logic       m_backlight_on;

    // shadow copy of the engine state
    logic [7:0] shadow_screen [0:ROWS-1][0:COLUMNS-1];
    logic       shadow_row;
    logic [4:0] shadow_col;
    logic [6:0] shadow_bright;

    // words still owed by the block, oldest first
    screen_result_t results_due [$];
    int error_count = 0;

    // sender burst control
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // receiver stall control; hold_ask is a one-off request from the tests
    int         hold_ask  = 0;
    int         hold_left = 0;
    logic [15:0] stall_pattern = '1;
    logic [3:0]  stall_phase   = '0;

    always #5 aclk = ~aclk;

    char_display_text_engine_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_char_code    (s_char_code),
        .s_action_code  (s_action_code),
        .s_repeat_count (s_repeat_count),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cell_data    (m_cell_data),
        .m_cursor_row   (m_cursor_row),
        .m_cursor_col   (m_cursor_col),
        .m_backlight_on (m_backlight_on)
    );

    // ------------------------------------------------------------------------
    // Shadow screen behaviour
    // ------------------------------------------------------------------------

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                shadow_screen[r][c] = cdte_pkg::CH_BLANK;
    endfunction

    // blank a span of the cursor row, last cell included
    function automatic void blank_span(int first, int last);
        for (int i = first; i <= last && i < COLUMNS; i++)
            shadow_screen[shadow_row][i] = cdte_pkg::CH_BLANK;
    endfunction

    // forward delete: pull the rest of the row left, pad with blanks
    function automatic void pull_row_left(int cnt);
        int n;
        if (cnt == 0 || shadow_col >= COLUMNS)
            return;
        n = COLUMNS - shadow_col;
        if (cnt < n)
            n = cnt;
        for (int i = shadow_col + n; i < COLUMNS; i++)
            shadow_screen[shadow_row][i - n] = shadow_screen[shadow_row][i];
        for (int i = COLUMNS - n; i < COLUMNS; i++)
            shadow_screen[shadow_row][i] = cdte_pkg::CH_BLANK;
    endfunction

    function automatic void apply_action(logic [3:0] code, int cnt);
        int t;
        case (code)
            cdte_pkg::ACT_BACKDEL: begin
                if (shadow_col != 0 && cnt != 0) begin
                    if (cnt > shadow_col)
                        cnt = shadow_col;
                    shadow_col = 5'(shadow_col - cnt);
                    pull_row_left(cnt);
                end
            end
            cdte_pkg::ACT_FWDDEL: pull_row_left(cnt);
            cdte_pkg::ACT_ERASE: begin
                if (cnt > 0 && shadow_col < COLUMNS) begin
                    t = shadow_col + cnt - 1;
                    if (t >= COLUMNS)
                        t = COLUMNS - 1;
                    blank_span(shadow_col, t);
                end
            end
            cdte_pkg::ACT_CLEAR: begin
                blank_screen();
                shadow_row = 1'b0;
                shadow_col = '0;
            end
            cdte_pkg::ACT_ERASEOL: begin
                if (shadow_col < COLUMNS)
                    blank_span(shadow_col, COLUMNS - 1);
            end
            cdte_pkg::ACT_HOME: begin
                shadow_row = 1'b0;
                shadow_col = '0;
            end
            cdte_pkg::ACT_END: shadow_col = 5'(COLUMNS - 1);
            cdte_pkg::ACT_LEFT: begin
                shadow_col = (cnt >= shadow_col) ? 5'd0 : 5'(shadow_col - cnt);
            end
            cdte_pkg::ACT_RIGHT: begin
                t = shadow_col + cnt;
                if (t >= COLUMNS)
                    t = COLUMNS - 1;
                shadow_col = 5'(t);
            end
            cdte_pkg::ACT_UP: begin
                shadow_row = (cnt >= shadow_row) ? 1'b0 : 1'(shadow_row - cnt);
            end
            cdte_pkg::ACT_DOWN: begin
                t = shadow_row + cnt;
                if (t >= ROWS)
                    t = ROWS - 1;
                shadow_row = 1'(t);
            end
            default: ;
        endcase
    endfunction

    // advance the shadow by one input word and return the word it owes
    function automatic screen_result_t engine_step(logic [1:0] kind, logic [7:0] ch,
                                                   logic [3:0] code, logic [7:0] cnt,
                                                   logic rrow, logic [3:0] rcol);
        screen_result_t res;
        res.char_out = 8'h00;
        if (kind == cdte_pkg::KIND_TEXT) begin
            if (ch < cdte_pkg::CH_BLANK) begin
                if (ch == cdte_pkg::CH_BS) begin
                    apply_action(cdte_pkg::ACT_BACKDEL, 1);
                end else if (ch == cdte_pkg::CH_CR) begin
                    shadow_col = '0;
                    apply_action(cdte_pkg::ACT_DOWN, 1);
                end
            end else if (ch == cdte_pkg::CH_DEL) begin
                apply_action(cdte_pkg::ACT_FWDDEL, 1);
            end else if (ch < CH_TOP && shadow_col < COLUMNS) begin
                shadow_screen[shadow_row][shadow_col[3:0]] = ch;
                shadow_col = shadow_col + 5'd1;
            end
        end else if (kind == cdte_pkg::KIND_ACTION) begin
            apply_action(code, cnt);
        end else if (kind == cdte_pkg::KIND_READ) begin
            if (rrow < ROWS && rcol < COLUMNS)
                res.char_out = shadow_screen[rrow][rcol];
        end
        res.row_out   = shadow_row;
        res.col_out   = shadow_col;
        res.light_out = (shadow_bright != 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stall pattern redrawn per phase wrap; long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                // a quarter of the time no stalls at all, else mostly ready
                if ($urandom_range(3) == 0)
                    stall_pattern = '1;
                else
                    stall_pattern = 16'($urandom | $urandom);
            end
            m_ready <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted word against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t  %s mismatch: expected %0h, actual %0h", $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        screen_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t  result word with nothing expected: data %0h row %0d col %0d",
                         $time, m_cell_data, m_cursor_row, m_cursor_col);
                error_count++;
            end else begin
                want = results_due.pop_front();
                check_field("cell_data", want.char_out, m_cell_data);
                check_field("cursor_row", want.row_out, m_cursor_row);
                check_field("cursor_col", want.col_out, m_cursor_col);
                check_field("backlight_on", want.light_out, m_backlight_on);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // offer one word, idling between bursts; predicts once the word is taken
    task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [3:0] code, input logic [7:0] cnt,
                             input logic rrow, input logic [3:0] rcol);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = gaps_on ? $urandom_range(12, 1) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_char_code    <= ch;
        s_action_code  <= code;
        s_repeat_count <= cnt;
        s_read_row     <= rrow;
        s_read_col     <= rcol;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        results_due.push_back(engine_step(kind, ch, code, cnt, rrow, rcol));
    endtask

    task automatic send_text(input logic [7:0] ch);
        send_word(cdte_pkg::KIND_TEXT, ch, cdte_pkg::ACT_BACKDEL, 8'd0, 1'b0, 4'd0);
    endtask

    task automatic send_action(input logic [3:0] code, input logic [7:0] cnt);
        send_word(cdte_pkg::KIND_ACTION, 8'h00, code, cnt, 1'b0, 4'd0);
    endtask

    task automatic send_read(input logic rrow, input logic [3:0] rcol);
        send_word(cdte_pkg::KIND_READ, 8'h00, cdte_pkg::ACT_BACKDEL, 8'd0, rrow, rcol);
    endtask

    // mostly well-formed editing traffic: printable runs, small counts,
    // frequent reads so the store contents are seen; the rest is noise
    task automatic send_random_word();
        int pick;
        logic [1:0] kind;
        logic [7:0] ch;
        logic [3:0] code;
        logic [7:0] cnt;
        ch   = 8'($urandom);
        code = 4'($urandom);
        cnt  = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 45)
            kind = cdte_pkg::KIND_TEXT;
        else if (pick < 75)
            kind = cdte_pkg::KIND_ACTION;
        else if (pick < 97)
            kind = cdte_pkg::KIND_READ;
        else
            kind = KIND_NONE;
        if (kind == cdte_pkg::KIND_TEXT) begin
            pick = $urandom_range(99);
            if (pick < 72)
                ch = 8'($urandom_range(8'h7E, 8'h20));
            else if (pick < 80)
                ch = cdte_pkg::CH_BS;
            else if (pick < 87)
                ch = cdte_pkg::CH_CR;
            else if (pick < 93)
                ch = cdte_pkg::CH_DEL;
        end else if (kind == cdte_pkg::KIND_ACTION) begin
            if ($urandom_range(99) < 8)
                code = 4'($urandom_range(15, int'(cdte_pkg::ACT_DOWN) + 1));
            else
                code = 4'($urandom_range(int'(cdte_pkg::ACT_DOWN)));
            pick = $urandom_range(99);
            if (pick < 60)
                cnt = 8'($urandom_range(4));
            else if (pick < 85)
                cnt = 8'($urandom_range(20));
        end
        send_word(kind, ch, code, cnt, 1'($urandom), 4'($urandom));
    endtask

    // stop offering and wait for every owed word
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
    endtask

    // register write only with the engine idle; allow for a walk still running
    task automatic write_brightness(input logic [6:0] level);
        wait_results_drained();
        repeat (COLUMNS + 2) @(posedge aclk);
        cfg_wdata <= level;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        // values over the maximum leave the register alone
        if (level <= cdte_pkg::MAX_BRIGHT)
            shadow_bright = level;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset contents, printable bytes, dropped bytes, backspace and DEL
    task automatic test_text_bytes();
        send_read(1'b0, 4'd0);
        send_text(8'h41);
        send_text(8'h7E);
        send_text(8'h00);
        send_text(8'h80);
        send_text(8'hFF);
        send_text(cdte_pkg::CH_BS);
        send_text(cdte_pkg::CH_DEL);
    endtask

    // cursor at and past the end of the row
    task automatic test_row_end();
        send_action(cdte_pkg::ACT_END, 8'd0);
        send_text(8'h20);
        send_text(8'h21);
        send_action(cdte_pkg::ACT_FWDDEL, 8'd5);
        send_action(cdte_pkg::ACT_ERASE, 8'd3);
        send_action(cdte_pkg::ACT_ERASEOL, 8'd0);
        send_action(cdte_pkg::ACT_RIGHT, 8'd0);
    endtask

    // carriage return and clamped moves with the largest count
    task automatic test_cursor_moves();
        send_text(cdte_pkg::CH_CR);
        send_action(cdte_pkg::ACT_DOWN, 8'd255);
        send_action(cdte_pkg::ACT_UP, 8'd255);
        send_action(cdte_pkg::ACT_RIGHT, 8'd255);
        send_action(cdte_pkg::ACT_LEFT, 8'd255);
    endtask

    // delete and erase extremes, clear, unused codes and kind
    task automatic test_edit_actions();
        send_action(cdte_pkg::ACT_END, 8'd0);
        send_action(cdte_pkg::ACT_BACKDEL, 8'd255);
        send_action(cdte_pkg::ACT_ERASE, 8'd0);
        send_action(cdte_pkg::ACT_ERASE, 8'd255);
        send_action(cdte_pkg::ACT_FWDDEL, 8'd0);
        send_action(cdte_pkg::ACT_HOME, 8'd0);
        send_action(cdte_pkg::ACT_CLEAR, 8'd0);
        send_action(4'd15, 8'hFF);
        send_word(KIND_NONE, 8'hFF, 4'hF, 8'hFF, 1'b1, 4'hF);
        send_read(1'b1, 4'd15);
    endtask

    // receiver holds off long enough to back the block up, then a full drain
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_ask = 400;
        repeat (40) send_random_word();
        wait_results_drained();
        gaps_on = 1'b1;
        repeat (20) send_random_word();
    endtask

    // random traffic under a range of brightness settings
    task automatic test_random_traffic();
        logic [6:0] levels [6];
        levels = '{7'd0, 7'd127, 7'd1, 7'd101, 7'd100, 7'($urandom_range(100))};
        foreach (levels[p]) begin
            write_brightness(levels[p]);
            // every other phase without sender gaps
            gaps_on = (p % 2 == 0);
            repeat (240) send_random_word();
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_wen        <= 1'b0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_kind         <= cdte_pkg::KIND_TEXT;
        s_char_code    <= '0;
        s_action_code  <= cdte_pkg::ACT_BACKDEL;
        s_repeat_count <= '0;
        s_read_row     <= 1'b0;
        s_read_col     <= '0;
        m_ready        <= 1'b0;
        blank_screen();
        shadow_row    = 1'b0;
        shadow_col    = '0;
        shadow_bright = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_text_bytes();
        write_brightness(cdte_pkg::MAX_BRIGHT);
        test_row_end();
        test_cursor_moves();
        test_edit_actions();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (COLUMNS + 4) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
